// ----- rtl/core/ptds_pkg.sv -----
`timescale 1ns / 1ps

package ptds_pkg;

    // Task table size; only the first four tasks have period registers and mask bits
    localparam int NUM_TASKS   = 4;
    localparam int PERIOD_REGS = 4;
    localparam int MAX_TASKS   = (NUM_TASKS < PERIOD_REGS) ? NUM_TASKS : PERIOD_REGS;
    localparam int CNT_W       = $clog2(MAX_TASKS + 1);
    localparam int IDX_W       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam int TICK_W      = 32;
    localparam int MASK_W      = 4;
    localparam int COUNT_W     = 3;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;

    // Register map, index = paddr / 4
    localparam logic [REG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RUN_LENGTH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_0   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_1   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_2   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_3   = 3'd5;

    typedef enum logic {
        OP_START = 1'b0,
        OP_POLL  = 1'b1
    } ptds_op_t;

    typedef struct packed {
        ptds_op_t            operation;
        logic [TICK_W-1:0]   now;
    } ptds_req_t;

    typedef struct packed {
        logic [MASK_W-1:0]   fire_mask;
        logic                run_over;
    } ptds_rsp_t;

endpackage

// ----- rtl/core/periodic_task_due_scheduler.sv -----
`timescale 1ns / 1ps

// Periodic task due-time scheduler. Issue a request by raising start while busy
// is low: operation OP_START latches now as the run's start tick and arms every
// task in use at now plus its period; OP_POLL checks the run length and fires
// each task in use whose due tick has been reached, re-arming it from its old
// due tick so missed slots catch up on later polls. Every request yields exactly
// one result, shown on result for a single cycle with done high; the receiver
// cannot stall it, so capture it on that edge. One 32-bit adder/subtractor does
// all the arithmetic and a small sequencer walks it over the tasks, one step a
// cycle. A start arms each task in use in turn. A poll with no run active
// reports over; an active poll checks the run length, which may end the run,
// then compares each task in use (task count clamped to MAX_TASKS), re-arming
// each that fires. busy stays high until the result is out. Write configuration
// over the APB port only while idle; the block does not enforce this.
module periodic_task_due_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    // request / result channel
    input  logic                        start,
    output logic                        busy,
    input  ptds_pkg::ptds_req_t         req,
    output logic                        done,
    output ptds_pkg::ptds_rsp_t         result,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptds_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ptds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM,
        S_CHECK_RUN,
        S_CMP,
        S_REARM
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]   task_count_reg;
    logic [TICK_W-1:0]    run_length_reg;
    logic [TICK_W-1:0]    period_reg [PERIOD_REGS];
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            run_length_reg <= '0;
            for (int i = 0; i < PERIOD_REGS; i++)
            begin
                period_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TASK_COUNT: task_count_reg <= pwdata[COUNT_W-1:0];
                REG_RUN_LENGTH: run_length_reg <= pwdata;
                REG_PERIOD_0:   period_reg[0]  <= pwdata;
                REG_PERIOD_1:   period_reg[1]  <= pwdata;
                REG_PERIOD_2:   period_reg[2]  <= pwdata;
                REG_PERIOD_3:   period_reg[3]  <= pwdata;
                default:        ;  // drop writes beyond the map
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TASK_COUNT: prdata = {{(32-COUNT_W){1'b0}}, task_count_reg};
            REG_RUN_LENGTH: prdata = run_length_reg;
            REG_PERIOD_0:   prdata = period_reg[0];
            REG_PERIOD_1:   prdata = period_reg[1];
            REG_PERIOD_2:   prdata = period_reg[2];
            REG_PERIOD_3:   prdata = period_reg[3];
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and task table
    // ------------------------------------------------------------------
    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TICK_W-1:0]    now_reg;
    logic [TICK_W-1:0]    start_tick_reg;
    logic [TICK_W-1:0]    due_reg [MAX_TASKS];
    logic                 running_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic                 done_reg;
    ptds_rsp_t            result_reg;

    logic [CNT_W-1:0]     n_use;
    logic [IDX_W-1:0]     task_idx;
    logic                 cnt_end;
    logic                 accept;

    // Clamp the task count to what the table and period registers cover
    assign n_use    = (task_count_reg > COUNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                             : CNT_W'(task_count_reg);
    assign task_idx = cnt_reg[IDX_W-1:0];
    assign cnt_end  = (cnt_reg == n_use);
    assign accept   = start && !busy;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Shared adder/subtractor: a + b, or a - b when sub is set
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] alu_a;
    logic [TICK_W-1:0] alu_b;
    logic              alu_sub;
    logic [TICK_W-1:0] alu_sum;
    logic [TICK_W-1:0] cur_period;
    logic [TICK_W-1:0] cur_due;

    assign cur_period = period_reg[2'(task_idx)];
    assign cur_due    = due_reg[task_idx];

    always_comb
    begin
        alu_a   = now_reg;
        alu_b   = cur_period;
        alu_sub = 1'b0;
        case (state_reg)
            S_ARM:
            begin
                // now + period
                alu_a   = now_reg;
                alu_b   = cur_period;
                alu_sub = 1'b0;
            end
            S_CHECK_RUN:
            begin
                // ticks elapsed since start
                alu_a   = now_reg;
                alu_b   = start_tick_reg;
                alu_sub = 1'b1;
            end
            S_CMP:
            begin
                // now - due, sign bit clear means due
                alu_a   = now_reg;
                alu_b   = cur_due;
                alu_sub = 1'b1;
            end
            S_REARM:
            begin
                // advance the due tick by one period
                alu_a   = cur_due;
                alu_b   = cur_period;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = now_reg;
                alu_b   = cur_period;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_b ^ {TICK_W{alu_sub}}) + {{(TICK_W-1){1'b0}}, alu_sub};

    // ------------------------------------------------------------------
    // Main sequencer: state, table and registered result
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            now_reg        <= '0;
            start_tick_reg <= '0;
            running_reg    <= 1'b0;
            mask_reg       <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                due_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg  <= req.now;
                        cnt_reg  <= '0;
                        mask_reg <= '0;
                        if (req.operation == OP_START)
                        begin
                            start_tick_reg <= req.now;
                            state_reg      <= S_ARM;
                        end
                        else if (!running_reg)
                        begin
                            // no run active: report over, leave the run and due table as they are
                            done_reg   <= 1'b1;
                            result_reg <= '{fire_mask: '0, run_over: 1'b1};
                        end
                        else
                        begin
                            state_reg <= S_CHECK_RUN;
                        end
                    end
                end
                S_ARM:
                begin
                    if (cnt_end)
                    begin
                        running_reg <= (run_length_reg != '0);
                        done_reg    <= 1'b1;
                        result_reg  <= '{fire_mask: '0,
                                         run_over: (run_length_reg == '0)};
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        due_reg[task_idx] <= alu_sum;
                        cnt_reg           <= cnt_reg + CNT_W'(1);
                    end
                end
                S_CHECK_RUN:
                begin
                    if (alu_sum >= run_length_reg)
                    begin
                        // run length elapsed: end the run
                        running_reg <= 1'b0;
                        done_reg    <= 1'b1;
                        result_reg  <= '{fire_mask: '0, run_over: 1'b1};
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (cnt_end)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= '{fire_mask: mask_reg, run_over: 1'b0};
                        state_reg  <= S_IDLE;
                    end
                    else if (!alu_sum[TICK_W-1])
                    begin
                        mask_reg[2'(task_idx)] <= 1'b1;
                        state_reg              <= S_REARM;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_REARM:
                begin
                    due_reg[task_idx] <= alu_sum;
                    cnt_reg           <= cnt_reg + CNT_W'(1);
                    state_reg         <= S_CMP;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while sequencer still busy");

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ARM || state_reg == S_CMP || state_reg == S_REARM)
            |-> (cnt_reg <= n_use))
        else $error("task counter ran past tasks in use");

    a_mask_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.fire_mask >> n_use) == '0))
        else $error("task beyond tasks in use fired");

    a_idle_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.operation == OP_POLL && !running_reg)
            |=> (done && result.run_over && result.fire_mask == '0))
        else $error("poll without an active run did not report over");

    a_over_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.run_over) |-> (result.fire_mask == '0))
        else $error("tasks fired on a result that reports run over");

endmodule
